FILE: hdl/fcw_pkg.sv
// Shared types and constants for the FAT12 cluster chain walker.
// No dependencies; used by every other file of the block.
package fcw_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int MAX_BLOCKS    = 64;

	// Each table row holds one packed group: two 12-bit entries.
	localparam int GROUPS     = (TABLE_ENTRIES + 1) / 2;
	localparam int ROW_W      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int ENTRY_W    = 12;
	localparam int SIZE_W     = 20;
	localparam int OFFSET_W   = 21;
	localparam int BLK_W      = 6;
	localparam int BLK_SHIFT  = 9;
	localparam int BLOCKS_W   = SIZE_W + 1 - BLK_SHIFT;
	localparam logic [8:0] BLOCK_ROUND = 9'h1ff;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_WALK = 1'b1;

	typedef enum logic [1:0] {
		PH_BYTE0 = 2'd0,
		PH_BYTE1 = 2'd1,
		PH_BYTE2 = 2'd2
	} fcw_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_EMIT  = 2'd1,
		ST_FETCH = 2'd2
	} fcw_state_t;

	typedef struct packed {
		logic                 opcode;
		logic [7:0]           table_byte;
		logic [ENTRY_W-1:0]   start_cluster;
		logic [SIZE_W-1:0]    file_size;
	} fcw_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0]   cluster;
		logic [OFFSET_W-1:0]  image_offset;
		logic [BLK_W-1:0]     block_number;
		logic                 last;
		logic                 truncated;
	} fcw_result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_byte;
		logic walk_start;
		logic emit;
		logic advance;
	} fcw_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic walk_empty;
		logic at_last;
	} fcw_status_t;

endpackage

FILE: hdl/fcw_ctrl.sv
// Controller state machine of the FAT12 cluster chain walker.
// Depends on fcw_pkg for the state, command and status types.
module fcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                opcode,
	input  fcw_pkg::fcw_status_t status,
	output fcw_pkg::fcw_cmd_t   cmd,
	output logic                busy,
	output logic                result_valid
);

	fcw_pkg::fcw_state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcw_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			fcw_pkg::ST_IDLE: begin
				if (start && opcode == fcw_pkg::OP_WALK && !status.walk_empty) begin
					state_next = fcw_pkg::ST_EMIT;
				end
			end
			fcw_pkg::ST_EMIT: begin
				if (status.at_last) begin
					state_next = fcw_pkg::ST_IDLE;
				end else begin
					state_next = fcw_pkg::ST_FETCH;
				end
			end
			fcw_pkg::ST_FETCH: begin
				state_next = fcw_pkg::ST_EMIT;
			end
			default: begin
				state_next = fcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		busy         = 1'b1;
		result_valid = 1'b0;
		case (state_q)
			fcw_pkg::ST_IDLE: begin
				busy           = 1'b0;
				cmd.load_byte  = start && opcode == fcw_pkg::OP_LOAD;
				cmd.walk_start = start && opcode == fcw_pkg::OP_WALK;
			end
			fcw_pkg::ST_EMIT: begin
				cmd.emit     = 1'b1;
				result_valid = 1'b1;
			end
			fcw_pkg::ST_FETCH: begin
				cmd.advance = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

FILE: hdl/fcw_datapath.sv
// Datapath of the FAT12 cluster chain walker: table memory, loader and walk registers.
// Depends on fcw_pkg; driven by commands from fcw_ctrl.
module fcw_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcw_pkg::fcw_req_t    request,
	input  fcw_pkg::fcw_cmd_t    cmd,
	output fcw_pkg::fcw_status_t status,
	output fcw_pkg::fcw_result_t result
);

	// One row per packed group: high half is the odd entry, low half the even one.
	logic [2*fcw_pkg::ENTRY_W-1:0] table_mem [fcw_pkg::GROUPS];

	fcw_pkg::fcw_phase_t             phase_q;
	logic [fcw_pkg::ROW_W-1:0]       group_q;
	logic [7:0]                      held0_q, held1_q;
	logic [2*fcw_pkg::ENTRY_W-1:0]   rd_data_q;
	logic [fcw_pkg::ENTRY_W-1:0]     cl_q;
	logic [fcw_pkg::BLK_W-1:0]       blk_q, last_idx_q;
	logic                            trunc_q;

	logic [fcw_pkg::SIZE_W:0]        size_round;
	logic [fcw_pkg::BLOCKS_W-1:0]    blocks;
	logic                            too_long;
	logic [fcw_pkg::BLK_W-1:0]       last_idx;
	logic [fcw_pkg::ROW_W-1:0]       rd_row;
	logic [fcw_pkg::ENTRY_W-1:0]     wr_even, wr_odd, next_cl;
	logic                            cl_in_table;

	assign size_round = {1'b0, request.file_size} + (fcw_pkg::SIZE_W + 1)'(fcw_pkg::BLOCK_ROUND);
	assign blocks     = size_round[fcw_pkg::SIZE_W:fcw_pkg::BLK_SHIFT];
	assign too_long   = blocks > fcw_pkg::BLOCKS_W'(fcw_pkg::MAX_BLOCKS);
	assign last_idx   = too_long ? fcw_pkg::BLK_W'(fcw_pkg::MAX_BLOCKS - 1)
	                             : fcw_pkg::BLK_W'(blocks - fcw_pkg::BLOCKS_W'(1));

	assign status.walk_empty = (blocks == '0);
	assign status.at_last    = (blk_q == last_idx_q);

	assign wr_even = {held1_q[3:0], held0_q};
	assign wr_odd  = {request.table_byte, held1_q[7:4]};

	assign rd_row      = fcw_pkg::ROW_W'(cl_q >> 1);
	assign cl_in_table = 32'(cl_q) < 32'(fcw_pkg::TABLE_ENTRIES);

	// A cluster past the end of the table links to cluster zero.
	always_comb begin
		if (!cl_in_table) begin
			next_cl = '0;
		end else if (cl_q[0]) begin
			next_cl = rd_data_q[2*fcw_pkg::ENTRY_W-1:fcw_pkg::ENTRY_W];
		end else begin
			next_cl = rd_data_q[fcw_pkg::ENTRY_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte && phase_q == fcw_pkg::PH_BYTE2) begin
			table_mem[group_q] <= {wr_odd, wr_even};
		end
		if (cmd.emit) begin
			rd_data_q <= table_mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fcw_pkg::PH_BYTE0;
			group_q <= '0;
			held0_q <= '0;
			held1_q <= '0;
		end else if (cmd.load_byte) begin
			case (phase_q)
				fcw_pkg::PH_BYTE0: begin
					held0_q <= request.table_byte;
					phase_q <= fcw_pkg::PH_BYTE1;
				end
				fcw_pkg::PH_BYTE1: begin
					held1_q <= request.table_byte;
					phase_q <= fcw_pkg::PH_BYTE2;
				end
				fcw_pkg::PH_BYTE2: begin
					phase_q <= fcw_pkg::PH_BYTE0;
					if (32'(group_q) + 32'd1 >= 32'(fcw_pkg::GROUPS)) begin
						group_q <= '0;
					end else begin
						group_q <= group_q + fcw_pkg::ROW_W'(1);
					end
				end
				default: begin
					phase_q <= fcw_pkg::PH_BYTE0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			cl_q       <= request.start_cluster;
			blk_q      <= '0;
			last_idx_q <= last_idx;
			trunc_q    <= too_long;
		end else if (cmd.advance) begin
			cl_q  <= next_cl;
			blk_q <= blk_q + fcw_pkg::BLK_W'(1);
		end
	end

	assign result.cluster      = cl_q;
	assign result.image_offset = {cl_q, {fcw_pkg::BLK_SHIFT{1'b0}}};
	assign result.block_number = blk_q;
	assign result.last         = status.at_last;
	assign result.truncated    = status.at_last & trunc_q;

endmodule

FILE: hdl/fat12_cluster_chain_walker.sv
// FAT12 cluster chain walker. A load request gives no result.
// A walk request of n blocks (n = ceil(file_size / 512), at most 64) alternates two states:
// the emit state shows each result and the fetch state waits on the dependent table read.
// The first result shows in the cycle right after the walk request is taken.
// A zero-size walk gives no result. busy is high while a walk runs; results cannot stall.
// Reset clears the controller and the load position; the table holds garbage until loaded.
module fat12_cluster_chain_walker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  fcw_pkg::fcw_req_t    request,
	output logic                 busy,
	output logic                 result_valid,
	output fcw_pkg::fcw_result_t result
);

	fcw_pkg::fcw_cmd_t    cmd;
	fcw_pkg::fcw_status_t status;

	fcw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.opcode       (request.opcode),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	fcw_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.status  (status),
		.result  (result)
	);

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the FAT12 cluster chain walker.
// Depends on fcw_pkg (hdl/fcw_pkg.sv) and fat12_cluster_chain_walker with fcw_ctrl and fcw_datapath.
// Directed rows come first, then random loads and walks that stay inside the loaded table.
`timescale 1ns / 100ps

module testbench;
	import fcw_pkg::*;

	localparam int RANDOM_ITEMS   = 165;
	localparam int QUIET_TAIL     = 40;
	localparam int DIRECTED_ITEMS = 32;
	localparam int SLOWEST_ITEM   = 2 * MAX_BLOCKS + 20;
	localparam int CYCLE_LIMIT    = 3 * (DIRECTED_ITEMS + RANDOM_ITEMS) * SLOWEST_ITEM;

	typedef struct {
		fcw_req_t    req;
		bit          typed;
		int          typed_count;
		fcw_result_t typed_block;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	fcw_req_t    request;
	logic        busy;
	logic        result_valid;
	fcw_result_t result;

	// Shadow copy of the block's table and loader.
	logic [ENTRY_W-1:0] fat_shadow [TABLE_ENTRIES];
	bit                 entry_written [TABLE_ENTRIES];
	int                 entries_loaded = 0;
	logic [12:0]        bytes_taken;
	logic [7:0]         held_b0;
	logic [7:0]         held_b1;
	logic [ENTRY_W-1:0] tgt_even;
	logic [ENTRY_W-1:0] tgt_odd;

	fcw_result_t expected_blocks [$];
	int          fails = 0;
	int          cycle_count = 0;

	fat12_cluster_chain_walker DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic void shadow_put(int idx, logic [ENTRY_W-1:0] value);
		if (idx < TABLE_ENTRIES) begin
			fat_shadow[idx]    = value;
			entry_written[idx] = 1'b1;
			if (idx + 1 > entries_loaded)
				entries_loaded = idx + 1;
		end
	endfunction

	// Number of blocks a walk from this cluster can take without leaving the loaded
	// entries; MAX_BLOCKS + 1 means the chain never leaves them.
	function automatic int safe_blocks(logic [ENTRY_W-1:0] start_cl);
		int                 count;
		logic [ENTRY_W-1:0] cl;
		count = 1;
		cl    = start_cl;
		while (count <= MAX_BLOCKS && entry_written[cl]) begin
			cl = fat_shadow[cl];
			count++;
		end
		return count;
	endfunction

	// Table bytes are chosen so that every loaded entry links into the loaded region.
	function automatic logic [7:0] next_load_byte();
		int         top;
		logic [1:0] phase_idx;
		logic [7:0] b;
		phase_idx = 2'(bytes_taken % 3);
		top       = 2 * int'(bytes_taken / 3) + 1;
		if (top > TABLE_ENTRIES - 1)
			top = TABLE_ENTRIES - 1;
		case (fcw_phase_t'(phase_idx))
			PH_BYTE0: begin
				tgt_even = ENTRY_W'($urandom_range(0, top));
				tgt_odd  = ENTRY_W'($urandom_range(0, top));
				b        = tgt_even[7:0];
			end
			PH_BYTE1: begin
				b = {tgt_odd[3:0], tgt_even[11:8]};
			end
			default: begin
				b = tgt_odd[11:4];
			end
		endcase
		return b;
	endfunction

	function automatic void predict_request(fcw_req_t r);
		int                 group;
		int                 blocks;
		int                 emit;
		bit                 trunc;
		logic [1:0]         phase_idx;
		logic [SIZE_W:0]    rounded;
		logic [ENTRY_W-1:0] cl;
		fcw_result_t        blk;
		if (r.opcode == OP_LOAD) begin
			phase_idx = 2'(bytes_taken % 3);
			case (fcw_phase_t'(phase_idx))
				PH_BYTE0: begin
					held_b0 = r.table_byte;
					bytes_taken = bytes_taken + 13'd1;
				end
				PH_BYTE1: begin
					held_b1 = r.table_byte;
					bytes_taken = bytes_taken + 13'd1;
				end
				default: begin
					group = int'(bytes_taken / 3);
					shadow_put(2 * group, {held_b1[3:0], held_b0});
					shadow_put(2 * group + 1, {r.table_byte, held_b1[7:4]});
					// The group that reaches the end of the table wraps the loader to entry 0.
					if (group + 1 >= GROUPS)
						bytes_taken = '0;
					else
						bytes_taken = bytes_taken + 13'd1;
				end
			endcase
		end else begin
			rounded = {1'b0, r.file_size} + BLOCK_ROUND;
			blocks = int'(rounded >> BLK_SHIFT);
			trunc = blocks > MAX_BLOCKS;
			emit = trunc ? MAX_BLOCKS : blocks;
			cl = r.start_cluster;
			for (int k = 0; k < emit; k++) begin
				blk.cluster      = cl;
				blk.image_offset = {cl, {BLK_SHIFT{1'b0}}};
				blk.block_number = k[BLK_W-1:0];
				blk.last         = (k + 1 == emit);
				blk.truncated    = (k + 1 == emit) && trunc;
				expected_blocks.push_back(blk);
				cl = (cl < TABLE_ENTRIES) ? fat_shadow[cl] : '0;
			end
		end
	endfunction

	function automatic stim_row_t load_row(logic [7:0] b);
		stim_row_t row;
		row.req            = '0;
		row.req.opcode     = OP_LOAD;
		row.req.table_byte = b;
		row.typed          = 1'b0;
		row.typed_count    = 0;
		row.typed_block    = '0;
		return row;
	endfunction

	function automatic stim_row_t walk_row(logic [ENTRY_W-1:0] cl, logic [SIZE_W-1:0] size,
		bit typed, int count, fcw_result_t blk);
		stim_row_t row;
		row.req               = '0;
		row.req.opcode        = OP_WALK;
		row.req.start_cluster = cl;
		row.req.file_size     = size;
		row.typed             = typed;
		row.typed_count       = count;
		row.typed_block       = blk;
		return row;
	endfunction

	function automatic logic [SIZE_W-1:0] random_file_size();
		logic [SIZE_W-1:0] size;
		case ($urandom_range(0, 9))
			0:       size = '0;
			1, 2, 3: size = SIZE_W'($urandom_range(1, 2048));
			4, 5:    size = SIZE_W'($urandom_range(1, 8192));
			6:       size = SIZE_W'($urandom_range(1, MAX_BLOCKS) * 512);
			7:       size = SIZE_W'($urandom_range(MAX_BLOCKS * 512 + 1, (1 << SIZE_W) - 1));
			8:       size = SIZE_W'($urandom);
			default: size = SIZE_W'(MAX_BLOCKS * 512 + $urandom_range(0, 1));
		endcase
		return size;
	endfunction

	// Drives one request at the falling edge, waits until it is taken, and books its results.
	task automatic run_item(input fcw_req_t r, input int idle_odds, input bit typed,
		input int count, input fcw_result_t blk);
		if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (typed) begin
			repeat (count)
				expected_blocks.push_back(blk);
		end else begin
			predict_request(r);
		end
		@(negedge clk);
	endtask

	always @(posedge clk) begin : result_check
		fcw_result_t want;
		if (arst_n && result_valid) begin
			if (expected_blocks.size() == 0) begin
				$error("unexpected result: cluster %0d block %0d", result.cluster,
					result.block_number);
				fails++;
			end else begin
				want = expected_blocks.pop_front();
				if (result.cluster !== want.cluster) begin
					$error("cluster: expected %0d, got %0d", want.cluster, result.cluster);
					fails++;
				end
				if (result.image_offset !== want.image_offset) begin
					$error("image_offset: expected %0h, got %0h", want.image_offset,
						result.image_offset);
					fails++;
				end
				if (result.block_number !== want.block_number) begin
					$error("block_number: expected %0d, got %0d", want.block_number,
						result.block_number);
					fails++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, result.last);
					fails++;
				end
				if (result.truncated !== want.truncated) begin
					$error("truncated: expected %0b, got %0b", want.truncated, result.truncated);
					fails++;
				end
			end
		end
	end

	initial begin
		stim_row_t rows [$];
		fcw_req_t  r;
		bit        idle_on;
		int        odds;
		int        safe;
		int        need;

		arst_n      = 1'b0;
		start       = 1'b0;
		request     = '0;
		bytes_taken = '0;
		held_b0     = '0;
		held_b1     = '0;
		tgt_even    = '0;
		tgt_odd     = '0;

		// Zero-size walks right after reset touch no table entry.
		rows.push_back(walk_row(12'd0, 20'd0, 1'b1, 0, '0));
		rows.push_back(walk_row(12'hfff, 20'd0, 1'b1, 0, '0));
		// Entries 0..5 become 001 002 ff8 005 004 ff0: a short chain, an end-of-chain
		// code that is followed anyway, and a cluster that points at itself.
		rows.push_back(load_row(8'h01));
		rows.push_back(load_row(8'h20));
		rows.push_back(load_row(8'h00));
		rows.push_back(load_row(8'hf8));
		rows.push_back(load_row(8'h5f));
		rows.push_back(load_row(8'h00));
		rows.push_back(load_row(8'h04));
		rows.push_back(load_row(8'h00));
		rows.push_back(load_row(8'hff));
		rows.push_back(walk_row(12'd0, 20'd1, 1'b1, 1, '{12'd0, 21'h0, 6'd0, 1'b1, 1'b0}));
		rows.push_back(walk_row(12'd2, 20'd512, 1'b1, 1, '{12'd2, 21'h400, 6'd0, 1'b1, 1'b0}));
		rows.push_back(walk_row(12'd0, 20'd1536, 1'b0, 0, '0));
		rows.push_back(walk_row(12'd3, 20'd513, 1'b0, 0, '0));
		rows.push_back(walk_row(12'd4, SIZE_W'(MAX_BLOCKS * 512), 1'b0, 0, '0));
		rows.push_back(walk_row(12'd4, SIZE_W'(MAX_BLOCKS * 512 + 1), 1'b0, 0, '0));
		rows.push_back(walk_row(12'd4, 20'hfffff, 1'b0, 0, '0));
		rows.push_back(walk_row(12'hfff, 20'd1, 1'b1, 1,
			'{12'hfff, 21'h1ffe00, 6'd0, 1'b1, 1'b0}));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			run_item(rows[i].req, 4, rows[i].typed, rows[i].typed_count,
				rows[i].typed_block);
		end

		idle_on = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 16 == 0)
				idle_on = $urandom_range(0, 2) != 0;
			r.table_byte    = 8'($urandom);
			r.start_cluster = ENTRY_W'($urandom);
			r.file_size     = SIZE_W'($urandom);
			if ($urandom_range(0, 9) < 3) begin
				r.opcode     = OP_LOAD;
				r.table_byte = next_load_byte();
			end else begin
				r.opcode = OP_WALK;
				if (entries_loaded > 0 && $urandom_range(0, 3) != 0)
					r.start_cluster = ENTRY_W'($urandom_range(0, entries_loaded - 1));
				r.file_size = random_file_size();
				// Shorten walks whose chain would run into entries that were never loaded.
				safe = safe_blocks(r.start_cluster);
				need = int'(({1'b0, r.file_size} + BLOCK_ROUND) >> BLK_SHIFT);
				if (safe <= MAX_BLOCKS && need > safe)
					r.file_size = SIZE_W'(safe * 512 - $urandom_range(0, 511));
			end
			odds = (idle_on && n < RANDOM_ITEMS - QUIET_TAIL) ? 3 : 0;
			run_item(r, odds, 1'b0, 0, '0);
		end
		start <= 1'b0;

		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (2 * MAX_BLOCKS + 8) @(posedge clk);
		if (fails == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
